FILE: design/pcrm_pkg.sv
// Shared types, constants and conversion functions for the PCM RMS level meter.
`timescale 1ns / 1ps
package pcrm_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W      = 30 + COUNT_W;
    localparam int REM_W      = COUNT_W + 1;
    localparam int STEP_W     = $clog2(SUM_W + 1);
    localparam int ROOT_STEPS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] REG_SAMPLE_FORMAT  = 2'd0;
    localparam logic [1:0] REG_MONO_INPUT     = 2'd1;
    localparam logic [1:0] REG_SMOOTHING_GAIN = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd6554;

    typedef enum logic [1:0] {
        FMT_INT16   = 2'd0,
        FMT_INT24   = 2'd1,
        FMT_INT32   = 2'd2,
        FMT_FLOAT32 = 2'd3
    } fmt_t;

    typedef struct packed {
        fmt_t        sample_format;
        logic        mono_input;
        logic [15:0] smoothing_gain;
    } cfg_t;

    // one frame handed from the front end to the level engine
    typedef struct packed {
        logic [31:0]        left;
        logic [31:0]        right;
        logic               last;
        logic [SUM_W-1:0]   sum_left;
        logic [SUM_W-1:0]   sum_right;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_SQRT,
        ST_MUL,
        ST_OUT
    } state_t;

    function automatic logic [31:0] float_to_q31(input logic [31:0] w);
        logic        neg;
        logic [7:0]  ex;
        logic [31:0] man;
        logic [31:0] mag;
        logic [7:0]  rs;
        neg = w[31];
        ex  = w[30:23];
        man = {8'd0, 1'b1, w[22:0]};
        rs  = 8'd119 - ex;
        mag = 32'd0;
        if (ex >= 8'd119) begin
            mag = man << 3'(ex - 8'd119);
        end else if (rs < 8'd32) begin
            mag = man >> rs[4:0];
        end
        if (ex == 8'hFF && w[22:0] != 23'd0) begin
            float_to_q31 = 32'd0;
        end else if (ex >= 8'd127) begin
            float_to_q31 = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (ex == 8'd0) begin
            float_to_q31 = 32'd0;
        end else begin
            float_to_q31 = neg ? (32'd0 - mag) : mag;
        end
    endfunction

    function automatic logic [31:0] convert(input fmt_t fmt, input logic [31:0] raw);
        unique case (fmt)
            FMT_INT16: convert = {raw[15:0], 16'd0};
            FMT_INT24: convert = {raw[23:0], 8'd0};
            FMT_INT32: convert = raw;
            default:   convert = float_to_q31(raw);
        endcase
    endfunction

endpackage

FILE: design/pcm_convert_rms_level_meter.sv
// Top level of the PCM converter with per-buffer RMS level meter.
`timescale 1ns / 1ps
// Usage:
//   s_ channel takes one stereo frame per beat: tdata holds the raw words,
//   tuser the silent flag, tlast the end-of-buffer mark.
//   m_ channel returns one beat per frame: converted Q1.31 samples and the
//   smoothed Q1.15 levels; tuser is high on the beat of a buffer end, whose
//   levels already include that buffer.
//   cfg_wr_en / cfg_addr / cfg_wdata write the format, mono and gain
//   registers; write only while the block is idle.
// Timing:
//   An ordinary frame goes front end -> 4-entry queue -> output register;
//   one frame per cycle sustained while the receiver is ready and no
//   buffer end is in work. A buffer-end frame holds the level engine for
//   43 divide steps, 16 root steps, multiply and update; the queue keeps
//   taking frames until its four entries are full.
// Reset (aresetn low, synchronous) clears the sums, levels, queue and
// registers to their defaults. When the receiver stalls, the output
// register holds its beat, the queue fills and s_tready drops.
module pcm_convert_rms_level_meter
    import pcrm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // left_raw[31:0], right_raw[63:32]
    input  logic [0:0]   s_tuser,   // silent
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // left_sample, right_sample, level_left, level_right
    output logic [0:0]   m_tuser    // level_valid
);

    cfg_t   cfg_reg;
    logic   push, full, pop, empty;
    entry_t push_entry, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{sample_format: FMT_INT16, mono_input: 1'b0,
                         smoothing_gain: GAIN_RESET};
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SAMPLE_FORMAT:  cfg_reg.sample_format  <= fmt_t'(cfg_wdata[1:0]);
                REG_MONO_INPUT:     cfg_reg.mono_input     <= cfg_wdata[0];
                REG_SMOOTHING_GAIN: cfg_reg.smoothing_gain <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pcrm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .left_raw       (s_tdata[31:0]),
        .right_raw      (s_tdata[63:32]),
        .silent         (s_tuser[0]),
        .last_of_buffer (s_tlast),
        .push           (push),
        .push_entry     (push_entry),
        .fifo_full      (full)
    );

    pcrm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (head),
        .empty      (empty)
    );

    pcrm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gain       (cfg_reg.smoothing_gain),
        .fifo_empty (empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: design/pcrm_front.sv
// Front end: format conversion and per-buffer square accumulation.
`timescale 1ns / 1ps
module pcrm_front
    import pcrm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] left_raw,
    input  logic [31:0] right_raw,
    input  logic        silent,
    input  logic        last_of_buffer,
    output logic        push,
    output entry_t      push_entry,
    input  logic        fifo_full
);

    logic [SUM_W-1:0]   sum_left_reg, sum_left_next;
    logic [SUM_W-1:0]   sum_right_reg, sum_right_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        l, r;
    logic signed [31:0] sq_l, sq_r;
    logic [SUM_W-1:0]   acc_l, acc_r;
    logic [COUNT_W-1:0] acc_n;

    assign in_ready = !fifo_full;
    assign push     = in_valid && in_ready;

    always_comb begin
        l = 32'd0;
        r = 32'd0;
        if (!silent) begin
            l = convert(cfg.sample_format, left_raw);
            r = cfg.mono_input ? l : convert(cfg.sample_format, right_raw);
        end
        sq_l = $signed(l[31:16]) * $signed(l[31:16]);
        sq_r = $signed(r[31:16]) * $signed(r[31:16]);
        acc_l = sum_left_reg;
        acc_r = sum_right_reg;
        acc_n = count_reg;
        if (count_reg < COUNT_W'(MAX_FRAMES)) begin
            acc_l = sum_left_reg + SUM_W'(unsigned'(sq_l));
            acc_r = sum_right_reg + SUM_W'(unsigned'(sq_r));
            acc_n = count_reg + 1'b1;
        end
        sum_left_next  = acc_l;
        sum_right_next = acc_r;
        count_next     = acc_n;
        if (last_of_buffer) begin
            sum_left_next  = '0;
            sum_right_next = '0;
            count_next     = '0;
        end
        push_entry = '{left: l, right: r, last: last_of_buffer,
                       sum_left: acc_l, sum_right: acc_r, count: acc_n};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_left_reg  <= '0;
            sum_right_reg <= '0;
            count_reg     <= '0;
        end else if (push) begin
            sum_left_reg  <= sum_left_next;
            sum_right_reg <= sum_right_next;
            count_reg     <= count_next;
        end
    end

endmodule

FILE: design/pcrm_fifo.sv
// Short frame queue between front end and level engine.
`timescale 1ns / 1ps
module pcrm_fifo
    import pcrm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   empty
);

    entry_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   fill_reg;

    assign full      = fill_reg == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign empty     = fill_reg == '0;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      fill_reg <= fill_reg + 1'b1;
            else if (pop && !push) fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

FILE: design/pcrm_back.sv
// Level engine: mean-square divide, integer root, leaky integrator, output register.
`timescale 1ns / 1ps
module pcrm_back
    import pcrm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [15:0]  gain,
    input  logic         fifo_empty,
    input  entry_t       head,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,
    output logic [0:0]   m_tuser
);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [31:0]         hold_l_reg, hold_r_reg;
    logic [COUNT_W-1:0]  div_reg;
    logic [REM_W-1:0]    rem_l_reg, rem_r_reg;
    logic [SUM_W-1:0]    quo_l_reg, quo_r_reg;
    logic [31:0]         x_l_reg, x_r_reg, res_l_reg, res_r_reg, bit_reg;
    logic signed [49:0]  prod_l_reg, prod_r_reg;
    logic [31:0]         smooth_l_reg, smooth_r_reg;
    logic                out_valid_reg;
    logic [95:0]         out_data_reg;
    logic                out_user_reg;

    logic                out_free, take_plain, take_last, deliver;
    logic [REM_W-1:0]    sh_l, sh_r;
    logic                ge_l, ge_r;
    logic [31:0]         t_l, t_r;
    logic signed [33:0]  d_l, d_r;
    logic [31:0]         new_l, new_r;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!fifo_empty && head.last) state_next = ST_DIV;
            ST_DIV:  if (step_reg == STEP_W'(SUM_W - 1)) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_SQRT;
            ST_SQRT: if (step_reg == STEP_W'(ROOT_STEPS - 1)) state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        take_plain = 1'b0;
        take_last  = 1'b0;
        deliver    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                take_plain = !fifo_empty && !head.last && out_free;
                take_last  = !fifo_empty && head.last;
            end
            ST_OUT:  deliver = out_free;
            default: ;
        endcase
        pop = take_plain || take_last;
    end

    always_comb begin
        sh_l = {rem_l_reg[REM_W-2:0], quo_l_reg[SUM_W-1]};
        sh_r = {rem_r_reg[REM_W-2:0], quo_r_reg[SUM_W-1]};
        ge_l = sh_l >= REM_W'(div_reg);
        ge_r = sh_r >= REM_W'(div_reg);
        t_l  = res_l_reg + bit_reg;
        t_r  = res_r_reg + bit_reg;
        d_l  = $signed({2'b00, res_l_reg[15:0], 16'd0}) - $signed({2'b00, smooth_l_reg});
        d_r  = $signed({2'b00, res_r_reg[15:0], 16'd0}) - $signed({2'b00, smooth_r_reg});
        // arithmetic shift gives the floor of the scaled step for both signs
        new_l = smooth_l_reg + 32'(prod_l_reg >>> 16);
        new_r = smooth_r_reg + 32'(prod_r_reg >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            smooth_l_reg  <= '0;
            smooth_r_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg != state_next) step_reg <= '0;
            else                         step_reg <= step_reg + 1'b1;
            if (take_plain || deliver)   out_valid_reg <= 1'b1;
            else if (m_tready)           out_valid_reg <= 1'b0;
            if (deliver) begin
                smooth_l_reg <= new_l;
                smooth_r_reg <= new_r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_plain) begin
            out_data_reg <= {smooth_r_reg[31:16], smooth_l_reg[31:16], head.right, head.left};
            out_user_reg <= 1'b0;
        end
        if (deliver) begin
            out_data_reg <= {new_r[31:16], new_l[31:16], hold_r_reg, hold_l_reg};
            out_user_reg <= 1'b1;
        end
        if (take_last) begin
            hold_l_reg <= head.left;
            hold_r_reg <= head.right;
            div_reg    <= (head.count == '0) ? COUNT_W'(1) : head.count;
            quo_l_reg  <= head.sum_left;
            quo_r_reg  <= head.sum_right;
            rem_l_reg  <= '0;
            rem_r_reg  <= '0;
        end
        if (state_reg == ST_DIV) begin
            rem_l_reg <= ge_l ? sh_l - REM_W'(div_reg) : sh_l;
            rem_r_reg <= ge_r ? sh_r - REM_W'(div_reg) : sh_r;
            quo_l_reg <= {quo_l_reg[SUM_W-2:0], ge_l};
            quo_r_reg <= {quo_r_reg[SUM_W-2:0], ge_r};
        end
        if (state_reg == ST_LOAD) begin
            x_l_reg   <= quo_l_reg[31:0];
            x_r_reg   <= quo_r_reg[31:0];
            res_l_reg <= '0;
            res_r_reg <= '0;
            bit_reg   <= 32'h4000_0000;
        end
        if (state_reg == ST_SQRT) begin
            if (x_l_reg >= t_l) begin
                x_l_reg   <= x_l_reg - t_l;
                res_l_reg <= (res_l_reg >> 1) + bit_reg;
            end else begin
                res_l_reg <= res_l_reg >> 1;
            end
            if (x_r_reg >= t_r) begin
                x_r_reg   <= x_r_reg - t_r;
                res_r_reg <= (res_r_reg >> 1) + bit_reg;
            end else begin
                res_r_reg <= res_r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == ST_MUL) begin
            prod_l_reg <= 50'(d_l) * 50'($signed({1'b0, gain}));
            prod_r_reg <= 50'(d_r) * 50'($signed({1'b0, gain}));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_smooth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        smooth_l_reg <= 32'h8000_0000 && smooth_r_reg <= 32'h8000_0000)
        else $error("smoothed level out of range");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> res_l_reg <= 32'd32768 && res_r_reg <= 32'd32768)
        else $error("rms root out of range");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_reg != '0)
        else $error("divide by zero count");

    a_deliver_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        deliver |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("level result not delivered");

endmodule
